@@ design/gbc_pkg.sv @@
// Package for the gyro bias calibrate-and-remove block.
// Holds the widths, the divide-by-count reciprocal, the lane control struct and saturation.
// No dependencies.
package gbc_pkg;

  localparam int SAMPLE_COUNT = 2000;
  localparam int SAMPLE_WIDTH = 16;
  localparam int THR_W        = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd1000;

  localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(SAMPLE_COUNT);
  // reciprocal scaling: 2^SHIFT > |sum| * count keeps the estimate within one of the quotient
  localparam int SHIFT   = SUM_W + CNT_W;
  localparam int RECIP_W = SHIFT - $clog2(SAMPLE_COUNT) + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((128'd1 << SHIFT) / SAMPLE_COUNT);
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam logic [SUM_W-1:0] HALF_COUNT = SUM_W'(SAMPLE_COUNT / 2);

  localparam int WIDE_W = SAMPLE_WIDTH + 2;
  localparam int CMP_W  = (WIDE_W > THR_W) ? WIDE_W : THR_W;

  localparam logic signed [WIDE_W-1:0] SMAX = WIDE_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] SMIN = -SMAX - WIDE_W'(1);

  typedef struct packed {
    logic clear;     // restart: drop the sum
    logic add;       // still sample: accumulate and hold it
    logic mag_en;    // offset pipeline: magnitude plus half count
    logic mul_en;    // offset pipeline: reciprocal multiply
    logic chk_en;    // offset pipeline: remainder
    logic fix_en;    // offset pipeline: correct, sign, saturate, load offset
    logic use_hold;  // correct the held sample instead of the live one
  } lane_ctrl_t;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sw(input logic signed [WIDE_W-1:0] v);
    logic signed [SAMPLE_WIDTH-1:0] res;
    if (v > SMAX) res = SMAX[SAMPLE_WIDTH-1:0];
    else if (v < SMIN) res = SMIN[SAMPLE_WIDTH-1:0];
    else res = v[SAMPLE_WIDTH-1:0];
    return res;
  endfunction

endpackage

@@ design/gbc_lane.sv @@
// One axis lane: running sum, pipelined rounded mean for the offset, offset removal.
// Depends on gbc_pkg.
module gbc_lane (
  input  logic                                    clk,
  input  logic                                    rst,
  input  gbc_pkg::lane_ctrl_t                     ctrl,
  input  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] smp,
  output logic        [gbc_pkg::SAMPLE_WIDTH-1:0] mag,
  output logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] rate
);

  logic signed [gbc_pkg::SUM_W-1:0]        sum;
  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] offset;
  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] hold;
  logic        [gbc_pkg::SUM_W-1:0]        m;
  logic                                    neg;
  logic        [gbc_pkg::PROD_W-1:0]       prod;
  logic        [gbc_pkg::Q_W-1:0]          q0;
  logic        [gbc_pkg::SUM_W-1:0]        r;

  logic signed [gbc_pkg::SAMPLE_WIDTH:0]   smp_neg;
  logic        [gbc_pkg::SUM_W-1:0]        sum_mag;
  logic        [gbc_pkg::Q_W-1:0]          q_est;
  logic        [gbc_pkg::Q_W-1:0]          q_fix;
  logic signed [gbc_pkg::Q_W:0]            q_s;
  logic signed [gbc_pkg::Q_W:0]            off_v;
  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] src;
  logic signed [gbc_pkg::WIDE_W-1:0]       diff;

  always_comb begin
    smp_neg = -((gbc_pkg::SAMPLE_WIDTH + 1)'(smp));
    mag     = smp[gbc_pkg::SAMPLE_WIDTH-1] ? smp_neg[gbc_pkg::SAMPLE_WIDTH-1:0] : smp;
    sum_mag = sum[gbc_pkg::SUM_W-1] ? -sum : sum;
    q_est   = prod[gbc_pkg::PROD_W-1:gbc_pkg::SHIFT];
    // estimate is the quotient or one short of it
    q_fix   = q0 + gbc_pkg::Q_W'(r >= gbc_pkg::SUM_W'(gbc_pkg::SAMPLE_COUNT));
    q_s     = $signed({1'b0, q_fix});
    off_v   = neg ? -q_s : q_s;
    src     = ctrl.use_hold ? hold : smp;
    diff    = gbc_pkg::WIDE_W'(src) - gbc_pkg::WIDE_W'(offset);
    rate    = gbc_pkg::sat_sw(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      offset <= '0;
    end else begin
      if (ctrl.clear) sum <= '0;
      else if (ctrl.add) sum <= sum + gbc_pkg::SUM_W'(smp);
      if (ctrl.fix_en) offset <= gbc_pkg::sat_sw(gbc_pkg::WIDE_W'(off_v));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add) hold <= smp;
    if (ctrl.mag_en) begin
      m   <= sum_mag + gbc_pkg::HALF_COUNT;
      neg <= sum[gbc_pkg::SUM_W-1];
    end
    if (ctrl.mul_en) prod <= gbc_pkg::PROD_W'(m) * gbc_pkg::PROD_W'(gbc_pkg::RECIP);
    if (ctrl.chk_en) begin
      q0 <= q_est;
      r  <= m - gbc_pkg::SUM_W'(q_est) * gbc_pkg::SUM_W'(gbc_pkg::SAMPLE_COUNT);
    end
  end

endmodule

@@ design/gbc_merge.sv @@
// Merging stage: sums the three lane magnitudes and compares against the motion threshold.
// Depends on gbc_pkg.
module gbc_merge (
  input  logic [gbc_pkg::SAMPLE_WIDTH-1:0] mag_x,
  input  logic [gbc_pkg::SAMPLE_WIDTH-1:0] mag_y,
  input  logic [gbc_pkg::SAMPLE_WIDTH-1:0] mag_z,
  input  logic [gbc_pkg::THR_W-1:0]        threshold,
  output logic                             still
);

  logic [gbc_pkg::CMP_W-1:0] total;

  always_comb begin
    total = gbc_pkg::CMP_W'(mag_x) + gbc_pkg::CMP_W'(mag_y) + gbc_pkg::CMP_W'(mag_z);
    still = !(total > gbc_pkg::CMP_W'(threshold));
  end

endmodule

@@ design/gyro_bias_calibrate_and_remove.sv @@
// Top level of the gyro bias calibrate-and-remove block.
// Depends on gbc_pkg, gbc_lane and gbc_merge.
//
// Input channel (in_valid/in_ready) carries mode and raw_x/y/z; mode 1 restarts
// calibration. Axes are remapped (x <- y, y <- -x saturated, z <- z), each in its
// own lane. While calibrating, a still sample (summed magnitude not above
// motion_threshold) is accumulated; one too lively is flagged rejected.
// Output channel (out_valid/out_ready) gives one result per input transfer:
// rates minus offsets, saturated, with calibrated and rejected flags.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes motion_threshold; always ready.
// An ordinary transfer's result is registered and valid in the next cycle. Throughput
// is one item per cycle while the receiver keeps up and the offset pipeline is idle.
// The sample that completes the count runs the offset pipeline (magnitude, reciprocal
// multiply, remainder, correction), and input is held off until its result is loaded
// into the output register.
// A stalled receiver holds the output register; a new item is taken while the held
// result is being transferred out.
// Reset: sums, offsets, count and calibration-done flag cleared, threshold 1000, no result pending.
module gyro_bias_calibrate_and_remove (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [gbc_pkg::THR_W-1:0]               cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    mode,
  input  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] raw_x,
  input  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] raw_y,
  input  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] raw_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] rate_x,
  output logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] rate_y,
  output logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] rate_z,
  output logic                                    calibrated,
  output logic                                    rejected
);

  typedef enum logic [5:0] {
    ST_RUN = 6'b000001,
    ST_MAG = 6'b000010,
    ST_MUL = 6'b000100,
    ST_CHK = 6'b001000,
    ST_FIX = 6'b010000,
    ST_OUT = 6'b100000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [gbc_pkg::THR_W-1:0]       threshold;
  logic [gbc_pkg::CNT_W-1:0]       count;
  logic                            done;

  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] s_x, s_y, s_z;
  logic        [gbc_pkg::SAMPLE_WIDTH-1:0] mag_x, mag_y, mag_z;
  logic signed [gbc_pkg::SAMPLE_WIDTH-1:0] cor_x, cor_y, cor_z;
  logic                            still;
  logic                            acc, sample, restart, take, last, out_free;
  gbc_pkg::lane_ctrl_t             ctrl;

  assign cfg_ready = 1'b1;

  always_comb begin
    s_x = raw_y;
    s_y = gbc_pkg::sat_sw(-gbc_pkg::WIDE_W'(raw_x));
    s_z = raw_z;

    out_free = !out_valid || out_ready;
    in_ready = (state == ST_RUN) && out_free;
    acc      = in_valid && in_ready;
    sample   = acc && !mode;
    restart  = acc && mode;
    take     = sample && !done && still;
    last     = take && (count == gbc_pkg::CNT_W'(gbc_pkg::SAMPLE_COUNT - 1));

    ctrl.clear    = restart;
    ctrl.add      = take;
    ctrl.mag_en   = (state == ST_MAG);
    ctrl.mul_en   = (state == ST_MUL);
    ctrl.chk_en   = (state == ST_CHK);
    ctrl.fix_en   = (state == ST_FIX);
    ctrl.use_hold = (state == ST_OUT);

    state_next = state;
    unique case (state)
      ST_RUN: if (last) state_next = ST_MAG;
      ST_MAG: state_next = ST_MUL;
      ST_MUL: state_next = ST_CHK;
      ST_CHK: state_next = ST_FIX;
      ST_FIX: state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  gbc_lane lane_x (.clk(clk), .rst(rst), .ctrl(ctrl), .smp(s_x), .mag(mag_x), .rate(cor_x));
  gbc_lane lane_y (.clk(clk), .rst(rst), .ctrl(ctrl), .smp(s_y), .mag(mag_y), .rate(cor_y));
  gbc_lane lane_z (.clk(clk), .rst(rst), .ctrl(ctrl), .smp(s_z), .mag(mag_z), .rate(cor_z));

  gbc_merge merge (
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z), .threshold(threshold), .still(still)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      threshold <= gbc_pkg::THR_RESET;
      count     <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (restart) begin
        count <= '0;
        done  <= 1'b0;
      end else if (take) begin
        count <= count + gbc_pkg::CNT_W'(1);
        if (last) done <= 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      // the completing sample is delivered from the offset pipeline instead
      if ((acc && !last) || ((state == ST_OUT) && out_free)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !last) begin
      if (restart) begin
        rate_x     <= '0;
        rate_y     <= '0;
        rate_z     <= '0;
        calibrated <= 1'b0;
        rejected   <= 1'b0;
      end else begin
        rate_x     <= cor_x;
        rate_y     <= cor_y;
        rate_z     <= cor_z;
        calibrated <= done;
        rejected   <= !done && !still;
      end
    end else if ((state == ST_OUT) && out_free) begin
      rate_x     <= cor_x;
      rate_y     <= cor_y;
      rate_z     <= cor_z;
      calibrated <= 1'b1;
      rejected   <= 1'b0;
    end
  end

  a_last_starts_div: assert property (@(posedge clk) disable iff (rst)
    last |=> (state == ST_MAG) && done)
    else $error("completing sample did not start the offset pipeline");

  a_fix_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |=> (state == ST_OUT) && done)
    else $error("offset load not followed by delivery");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !done |-> (count < gbc_pkg::CNT_W'(gbc_pkg::SAMPLE_COUNT)))
    else $error("sample count passed the target while calibrating");

  a_restart_result: assert property (@(posedge clk) disable iff (rst)
    restart |=> out_valid && !calibrated && !rejected && !done)
    else $error("restart result or state wrong");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(calibrated && rejected))
    else $error("result both calibrated and rejected");

endmodule
